FILE: hdl/ckmer_pkg.sv
package ckmer_pkg;

  localparam int MAX_K      = 32;
  localparam int BASE_W     = 2;
  localparam int KMER_W     = MAX_K * BASE_W;
  localparam int CHAR_W     = 8;
  localparam int K_W        = $clog2(MAX_K + 1);
  localparam int FILL_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = K_W;

  localparam logic [FILL_W-1:0] FILL_MAX   = '1;
  localparam logic [K_W-1:0]    K_RESET    = K_W'(31);
  localparam logic [K_W-1:0]    K_MIN      = K_W'(1);
  localparam logic [K_W-1:0]    K_MAX      = K_W'(MAX_K);

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [BASE_W-1:0] CODE_A = 2'd0;
  localparam logic [BASE_W-1:0] CODE_C = 2'd1;
  localparam logic [BASE_W-1:0] CODE_G = 2'd2;
  localparam logic [BASE_W-1:0] CODE_T = 2'd3;

  typedef logic [KMER_W-1:0] kmer_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LEN        = 2'd0,
    REG_CANONICAL_MODE = 2'd1
  } cfg_reg_t;

  // Map an ASCII nucleotide to its 2-bit code; anything unknown is A.
  function automatic logic [BASE_W-1:0] base_code(input logic [CHAR_W-1:0] ch);
    logic [BASE_W-1:0] code;
    unique case (ch)
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_A;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/canonical_kmer_stream.sv
// Canonical k-mer stream: takes one ASCII base per transaction on the in_ side (tlast marks
// the final base of a query), maps A/C/G/T to 0..3 (any other byte counts as A), and once k
// bases of the query are in, delivers one 2-bit-packed k-mer per base on the out_ side,
// first base in the most significant position of the low 2k bits; with canonical_mode set
// it delivers the lesser of the forward k-mer and its reverse complement. out_tlast marks
// the last result of a query; a query that ends with fewer than k bases delivers a single
// result with value zero, out_tlast and out_tuser set. The block sustains one base per
// cycle: stage one shifts the base into the forward and reverse-complement windows, stage
// two performs the 64-bit minimum compare into the output register, so each result is
// registered first in the stage-one windows and then in the output register, and in_tready
// drops only when both stages hold data and the downstream stalls. Write the
// window length (register 0: 1..32; 0 reads as 1, above 32 as 32) or canonical_mode
// (register 1) only while no transaction is in flight; a window length write restarts the
// current query.
module canonical_kmer_stream (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [ckmer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckmer_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ckmer_pkg::CHAR_W-1:0]     in_tdata,   // [7:0] base_char
  input  logic                             in_tlast,   // end_of_query
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ckmer_pkg::KMER_W-1:0]     out_tdata,  // [63:0] kmer_value
  output logic                             out_tlast,  // query_done
  output logic                             out_tuser   // too_short
);
  import ckmer_pkg::*;

  // configuration
  logic [K_W-1:0] win_len_r;
  logic           canonical_r;

  // window state, also the stage-one payload
  kmer_t             fwd_r, fwd_nxt;
  kmer_t             rev_r, rev_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // stage-one control
  logic s1_valid_r;
  logic s1_last_r;
  logic s1_short_r;

  // output register
  logic  out_valid_r;
  kmer_t out_data_r;
  logic  out_last_r;
  logic  out_short_r;

  logic              in_accept;
  logic              s1_adv;
  logic [K_W-1:0]    k_eff;
  logic [K_W-1:0]    k_m1;
  logic [K_W:0]      mask_sh;
  kmer_t             mask;
  kmer_t             rev_ins;
  logic [BASE_W-1:0] code;
  logic [BASE_W-1:0] comp;
  logic              full_kmer;
  kmer_t             result;

  // Clamp k into 1..MAX_K.
  always_comb begin
    priority if (win_len_r < K_MIN) begin
      k_eff = K_MIN;
    end else if (win_len_r > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = win_len_r;
    end
  end

  assign k_m1    = k_eff - K_MIN;
  assign mask_sh = {k_eff, 1'b0};
  // A shift of the full width gives zero, so k = MAX_K yields all ones.
  assign mask    = (kmer_t'(1) << mask_sh) - kmer_t'(1);

  assign code    = base_code(in_tdata);
  assign comp    = ~code;
  // Complement of the new base lands at the top base position of the window.
  assign rev_ins = kmer_t'(comp) << {k_m1, 1'b0};

  // Stage one advances into the output register when that is empty or being drained.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // Shift the base in. Windows are never cleared: after a restart k fresh bases
  // overwrite every bit under the mask before any k-mer is delivered. Drop the
  // top base position of the shifted reverse window so stale bits from a longer
  // window never merge with the inserted base.
  always_comb begin
    fwd_nxt  = fwd_r;
    rev_nxt  = rev_r;
    fill_nxt = fill_r;
    if (in_accept) begin
      fwd_nxt = ((fwd_r << BASE_W) | kmer_t'(code)) & mask;
      rev_nxt = ((rev_r >> BASE_W) & (mask >> BASE_W)) | rev_ins;
      if (fill_r != FILL_MAX) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  assign full_kmer = FILL_W'(k_eff) <= fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= K_RESET;
      canonical_r <= 1'b0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      // A window length write or the end of a query restarts the fill count.
      if (cfg_we && (cfg_reg_t'(cfg_index) == REG_WIN_LEN)) begin
        fill_r <= '0;
      end else if (in_accept && in_tlast) begin
        fill_r <= '0;
      end else begin
        fill_r <= fill_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WIN_LEN: begin
            win_len_r <= cfg_wdata;
          end
          REG_CANONICAL_MODE: begin
            canonical_r <= cfg_wdata[0];
          end
          default: begin
            // drop writes to unknown registers
          end
        endcase
      end
    end
  end

  // Stage-one payload: windows hold their value unless a transaction is accepted.
  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    rev_r <= rev_nxt;
    if (in_accept) begin
      s1_last_r  <= in_tlast;
      s1_short_r <= !full_kmer;
    end
  end

  // Stage two: zero for a too-short item, otherwise forward or the lesser strand.
  always_comb begin
    priority if (s1_short_r) begin
      result = '0;
    end else if (canonical_r && (rev_r < fwd_r)) begin
      result = rev_r;
    end else begin
      result = fwd_r;
    end
  end

  // Items that neither end the query nor complete a k-mer produce nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= !s1_short_r || s1_last_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r  <= result;
      out_last_r  <= s1_last_r;
      out_short_r <= s1_short_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_short_r;

  // A too-short result is always the zero-valued last result of its query.
  a_short_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("too-short result not zero or not last");

  // Backpressure reaches the input only when both stages are occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room in the pipeline");

  // End of query restarts the fill count.
  a_query_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast && !cfg_we |=> fill_r == '0)
    else $error("fill count not cleared at end of query");

  // Canonical selection never exceeds the forward k-mer.
  a_canon_min: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_short_r |=> (out_tdata <= $past(fwd_r)))
    else $error("result above forward k-mer");

endmodule
